// ===== sv/gmps_pkg.sv =====
// gmps_pkg: shared widths, register codes and reset values for the
// streaming minimum path sum block. No dependencies.
`timescale 1ns / 1ps

package gmps_pkg;

    // field widths
    localparam int COST_W = 8;
    localparam int SUM_W  = 20;
    localparam int CFG_W  = 11;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;

    // size register reset values
    localparam int RESET_GRID_COLUMNS = 3;
    localparam int RESET_GRID_ROWS    = 3;

    // default bounds for the top-level parameters
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;

    // largest representable path sum
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

// ===== sv/gmps_cell.sv =====
// gmps_cell: one stage of the row shift chain, holding one path sum.
// Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_cell
    import gmps_pkg::*;
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic             inject_sel,
    input  logic [SUM_W-1:0] inject_data,
    input  logic [SUM_W-1:0] next_data,
    output logic [SUM_W-1:0] data
);

    logic [SUM_W-1:0] data_reg;
    logic [SUM_W-1:0] data_next;

    // take the new sum at the row's tail, otherwise the neighbor's value
    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = inject_sel ? inject_data : next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/gmps_row_chain.sv =====
// gmps_row_chain: row of gmps_cell stages acting as a one-row delay line
// whose length follows the configured column count. Depends on gmps_pkg, gmps_cell.
`timescale 1ns / 1ps

module gmps_row_chain
    import gmps_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
)
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic [COL_W-1:0] cols_m1,
    input  logic [SUM_W-1:0] inject_data,
    output logic [SUM_W-1:0] above
);

    logic [SUM_W-1:0] cell_data [MAX_COLUMNS];

    // cell k feeds cell k-1; the new sum enters at cell cols-1
    for (genvar k = 0; k < MAX_COLUMNS; k++)
    begin : g_cell
        logic             sel;
        logic [SUM_W-1:0] nbr;

        assign sel = (cols_m1 == COL_W'(k));

        if (k == MAX_COLUMNS - 1)
        begin : g_tail
            assign nbr = inject_data;
        end
        else
        begin : g_body
            assign nbr = cell_data[k+1];
        end

        gmps_cell u_cell (
            .clk         (clk),
            .shift_en    (shift_en),
            .inject_sel  (sel),
            .inject_data (inject_data),
            .next_data   (nbr),
            .data        (cell_data[k])
        );
    end

    // head cell holds the sum above the current column
    assign above = cell_data[0];

endmodule

// ===== sv/grid_min_path_sum.sv =====
// grid_min_path_sum: streaming minimum path sum over a row-major grid.
// Depends on gmps_pkg, gmps_row_chain (which uses gmps_cell).
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | in_valid / in_ready    | cell_cost[7:0]
//   output   | out_valid / out_ready  | path_sum[19:0], row_end, grid_end
//   config   | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[10:0]
//
// One request per cycle while in_ready is high; a result is registered and
// appears in the cycle after its request, through one compare-add stage.
// The cell chain advances one cell per request, so the sum above is always at its head.
// Reset zeroes the counters and left sum and sets both sizes to 3; the
// chain is not cleared and is never read in the first row of a grid.
// in_ready drops only while a result is held and out_ready is low.
`timescale 1ns / 1ps

module grid_min_path_sum
    import gmps_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [COST_W-1:0]    cell_cost,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SUM_W-1:0]     path_sum,
    output logic                 row_end,
    output logic                 grid_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // size minus one after clamping to 1..maxv
    function automatic int clamp_m1(input int v, input int maxv);
        int r;
        r = v - 1;
        if (v == 0)
        begin
            r = 0;
        end
        else if (v > maxv)
        begin
            r = maxv - 1;
        end
        return r;
    endfunction

    logic [COL_W-1:0]  cols_m1_reg, cols_m1_next;
    logic [ROW_W-1:0]  rows_m1_reg, rows_m1_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SUM_W-1:0]  left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  path_sum_reg, path_sum_next;
    logic              row_end_reg, row_end_next;
    logic              grid_end_reg, grid_end_next;

    logic              in_accept;
    logic              cfg_write;
    logic [SUM_W-1:0]  above;
    logic [SUM_W-1:0]  best;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum;
    logic              at_row_end;
    logic              at_grid_end;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // previous row of sums
    gmps_row_chain #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W)
    ) u_chain (
        .clk         (clk),
        .shift_en    (in_accept),
        .cols_m1     (cols_m1_reg),
        .inject_data (sum),
        .above       (above)
    );

    // pick the cheaper neighbor and add the cell cost, saturating
    always_comb
    begin
        if (row_reg == '0 && col_reg == '0)
        begin
            best = '0;
        end
        else if (row_reg == '0)
        begin
            best = left_reg;
        end
        else if (col_reg == '0)
        begin
            best = above;
        end
        else
        begin
            best = (above < left_reg) ? above : left_reg;
        end
        sum_wide = {1'b0, best} + (SUM_W+1)'(cell_cost);
        sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    assign at_row_end  = (col_reg == cols_m1_reg);
    assign at_grid_end = at_row_end && (row_reg == rows_m1_reg);

    // position, left sum and size registers
    always_comb
    begin
        cols_m1_next = cols_m1_reg;
        rows_m1_next = rows_m1_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        left_next    = left_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_COLUMNS:
                begin
                    cols_m1_next = COL_W'(clamp_m1(int'(cfg_data), MAX_COLUMNS));
                    col_next     = '0;
                    row_next     = '0;
                    left_next    = '0;
                end
                REG_GRID_ROWS:
                begin
                    rows_m1_next = ROW_W'(clamp_m1(int'(cfg_data), MAX_ROWS));
                    col_next     = '0;
                    row_next     = '0;
                    left_next    = '0;
                end
                default:
                begin
                    cols_m1_next = cols_m1_reg;
                end
            endcase
        end
        else if (in_accept)
        begin
            left_next = sum;
            if (at_row_end)
            begin
                col_next = '0;
                row_next = at_grid_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        path_sum_next  = path_sum_reg;
        row_end_next   = row_end_reg;
        grid_end_next  = grid_end_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            path_sum_next  = sum;
            row_end_next   = at_row_end;
            grid_end_next  = at_grid_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_m1_reg   <= COL_W'(clamp_m1(RESET_GRID_COLUMNS, MAX_COLUMNS));
            rows_m1_reg   <= ROW_W'(clamp_m1(RESET_GRID_ROWS, MAX_ROWS));
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cols_m1_reg   <= cols_m1_next;
            rows_m1_reg   <= rows_m1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        path_sum_reg <= path_sum_next;
        row_end_reg  <= row_end_next;
        grid_end_reg <= grid_end_next;
    end

    assign out_valid = out_valid_reg;
    assign path_sum  = path_sum_reg;
    assign row_end   = row_end_reg;
    assign grid_end  = grid_end_reg;

endmodule

// ===== bench/grid_min_path_sum_tb.sv =====
// grid_min_path_sum_tb: self-checking bench for the streaming minimum path sum block.
// Depends on gmps_pkg and grid_min_path_sum. It runs a directed table, then random grids,
// with random gaps and stalls on both data channels.
`timescale 1ns / 1ps

module grid_min_path_sum_tb;
    import gmps_pkg::*;

    // unused register slots of the config port
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 2;
    localparam int END_CYCLES     = 8;
    localparam int RANDOM_CELLS   = 700;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [SUM_W-1:0] path_sum;
        logic             row_end;
        logic             grid_end;
    } path_result_t;

    typedef enum logic {PLAN_CELL, PLAN_WRITE} plan_kind_t;

    // one directed step: a cell (cost in the low bits of value) or a register write
    typedef struct packed {
        plan_kind_t           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
        logic                 checked;
        path_result_t         result;
    } plan_row_t;

    localparam int PLAN_LEN = 29;
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // 3x3 grid after reset, cost extremes
        '{PLAN_CELL,  '0,               11'd0,    1'b1, '{20'd0,   1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd255, 1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd510, 1'b1, 1'b0}},
        '{PLAN_CELL,  '0,               11'd1,    1'b1, '{20'd1,   1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd0,    1'b1, '{20'd1,   1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd7,    1'b1, '{20'd8,   1'b1, 1'b0}},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd256, 1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd0,    1'b1, '{20'd1,   1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd256, 1'b1, 1'b1}},
        // unknown index is ignored, grid restarts after its last cell
        '{PLAN_WRITE, REG_UNUSED_2,     11'd5,    1'b0, '0},
        '{PLAN_CELL,  '0,               11'd3,    1'b1, '{20'd3,   1'b0, 1'b0}},
        // zero columns acts as one
        '{PLAN_WRITE, REG_GRID_COLUMNS, 11'd0,    1'b0, '0},
        '{PLAN_CELL,  '0,               11'd10,   1'b1, '{20'd10,  1'b1, 1'b0}},
        '{PLAN_CELL,  '0,               11'd20,   1'b1, '{20'd30,  1'b1, 1'b0}},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd285, 1'b1, 1'b1}},
        // zero rows acts as one
        '{PLAN_WRITE, REG_GRID_ROWS,    11'd0,    1'b0, '0},
        '{PLAN_CELL,  '0,               11'd9,    1'b1, '{20'd9,   1'b1, 1'b1}},
        '{PLAN_WRITE, REG_UNUSED_3,     11'd2047, 1'b0, '0},
        '{PLAN_CELL,  '0,               11'd4,    1'b1, '{20'd4,   1'b1, 1'b1}},
        // oversized sizes act as the maximum
        '{PLAN_WRITE, REG_GRID_COLUMNS, 11'd2047, 1'b0, '0},
        '{PLAN_WRITE, REG_GRID_ROWS,    11'd2047, 1'b0, '0},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd255, 1'b0, 1'b0}},
        '{PLAN_CELL,  '0,               11'd255,  1'b1, '{20'd510, 1'b0, 1'b0}},
        // small 2x2 grid, checked by the predictor
        '{PLAN_WRITE, REG_GRID_COLUMNS, 11'd2,    1'b0, '0},
        '{PLAN_WRITE, REG_GRID_ROWS,    11'd2,    1'b0, '0},
        '{PLAN_CELL,  '0,               11'd17,   1'b0, '0},
        '{PLAN_CELL,  '0,               11'd200,  1'b0, '0},
        '{PLAN_CELL,  '0,               11'd255,  1'b0, '0},
        '{PLAN_CELL,  '0,               11'd0,    1'b0, '0}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [COST_W-1:0]    cell_cost = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SUM_W-1:0]     path_sum;
    logic                 row_end;
    logic                 grid_end;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predictor state
    logic [CFG_W-1:0] cols_reg = CFG_W'(RESET_GRID_COLUMNS);
    logic [CFG_W-1:0] rows_reg = CFG_W'(RESET_GRID_ROWS);
    logic [SUM_W-1:0] row_sums [DEF_MAX_COLUMNS];
    int               left_total = 0;
    int               col_pos = 0;
    int               row_pos = 0;

    path_result_t queued_sums [$];
    int           fail_count   = 0;
    int           quiet_cycles = 0;
    int           stall_left   = 0;
    bit           steady_in    = 1'b0;
    bit           steady_out   = 1'b0;

    grid_min_path_sum u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_cost (cell_cost),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .path_sum  (path_sum),
        .row_end   (row_end),
        .grid_end  (grid_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // size register as the block sees it
    function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // path sum of the next cell, advancing the grid position
    function automatic path_result_t step_grid(input logic [COST_W-1:0] cost);
        int           cols;
        int           rows;
        int           c;
        int           r;
        int           above;
        int           best;
        int           total;
        path_result_t res;
        cols = eff_size(cols_reg, DEF_MAX_COLUMNS);
        rows = eff_size(rows_reg, DEF_MAX_ROWS);
        c = (col_pos >= cols) ? 0 : col_pos;
        r = (row_pos >= rows) ? 0 : row_pos;
        above = int'(row_sums[c]);
        if (r == 0 && c == 0)
            best = 0;
        else if (r == 0)
            best = left_total;
        else if (c == 0)
            best = above;
        else
            best = (above < left_total) ? above : left_total;
        total = best + int'(cost);
        if (total > int'(SUM_MAX))
            total = int'(SUM_MAX);
        row_sums[c] = SUM_W'(total);
        left_total = total;
        res.path_sum = SUM_W'(total);
        res.row_end = (c + 1 == cols);
        res.grid_end = res.row_end && (r + 1 == rows);
        if (res.row_end)
        begin
            col_pos = 0;
            row_pos = res.grid_end ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        return res;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // size value with weight on the edges
    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return '0;
            1:       return CFG_W'(2047);
            2:       return CFG_W'(DEF_MAX_COLUMNS);
            3:       return CFG_W'($urandom_range(1025, 2047));
            4, 5:    return CFG_W'(1);
            default: return CFG_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return COST_W'($urandom_range(0, 255));
    endfunction

    // hold off new requests until every result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (queued_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one cell request; a typed result replaces the predicted one
    task automatic send_cell(input logic [COST_W-1:0] cost, input int gap,
                             input logic typed, input path_result_t typed_result);
        path_result_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cell_cost <= cost;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_grid(cost);
        queued_sums.push_back(typed ? typed_result : predicted);
    endtask

    // register write while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_COLUMNS || idx == REG_GRID_ROWS)
        begin
            if (idx == REG_GRID_COLUMNS)
                cols_reg = value;
            else
                rows_reg = value;
            col_pos = 0;
            row_pos = 0;
            left_total = 0;
        end
    endtask

    // random cells, with an occasional full drain in the middle
    task automatic stream_cells(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 63) == 0)
                drain_results();
            send_cell(pick_cost(), pick_gap(steady_in), 1'b0, '0);
        end
    endtask

    // result side backpressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!steady_out && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap(1'b0);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // compare each result with the oldest pending sum
    always @(posedge clk)
    begin
        path_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (queued_sums.size() == 0)
            begin
                $error("path_sum: no result pending, got %0d", path_sum);
                fail_count++;
            end
            else
            begin
                want = queued_sums.pop_front();
                if (path_sum !== want.path_sum)
                begin
                    $error("path_sum: expected %0d, got %0d", want.path_sum, path_sum);
                    fail_count++;
                end
                if (row_end !== want.row_end)
                begin
                    $error("row_end: expected %0d, got %0d", want.row_end, row_end);
                    fail_count++;
                end
                if (grid_end !== want.grid_end)
                begin
                    $error("grid_end: expected %0d, got %0d", want.grid_end, grid_end);
                    fail_count++;
                end
            end
        end
    end

    // stop a hung run: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("grid_min_path_sum_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int random_cells;
        int area;
        int count;
        random_cells = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (DIRECTED_PLAN[i].kind == PLAN_WRITE)
                write_register(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].value);
            else
                send_cell(DIRECTED_PLAN[i].value[COST_W-1:0], pick_gap(1'b0),
                          DIRECTED_PLAN[i].checked, DIRECTED_PLAN[i].result);
        end

        // random phases: new sizes, then whole grids or a partial one
        while (random_cells < RANDOM_CELLS)
        begin
            if ($urandom_range(0, 7) == 0)
                write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                               CFG_W'($urandom));
            if ($urandom_range(0, 3) != 0)
                write_register(REG_GRID_COLUMNS, pick_size());
            if ($urandom_range(0, 3) != 0)
                write_register(REG_GRID_ROWS, pick_size());
            area = eff_size(cols_reg, DEF_MAX_COLUMNS) * eff_size(rows_reg, DEF_MAX_ROWS);
            if (area <= 64)
            begin
                count = area * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    count += $urandom_range(0, area - 1);
            end
            else
                count = $urandom_range(1, 120);
            steady_in  = ($urandom_range(0, 4) == 0);
            steady_out = ($urandom_range(0, 4) == 0);
            stream_cells(count);
            random_cells += count;
        end

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("grid_min_path_sum_tb passed");
        else
            $display("grid_min_path_sum_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gmps_pkg.sv
sv/gmps_cell.sv
sv/gmps_row_chain.sv
sv/grid_min_path_sum.sv
bench/grid_min_path_sum_tb.sv
